FILE: design/tcw_pkg.sv
`default_nettype none
package tcw_pkg;

	localparam int WORD_W = 16;
	localparam int CELL_W = 16;

	localparam logic [7:0] CHAR_NUL     = 8'h00;
	localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
	localparam logic [7:0] CHAR_SPACE   = 8'h20;
	localparam logic [7:0] RESET_ATTR   = 8'h07;

	typedef enum logic [1:0] {
		OP_PUT  = 2'd0,
		OP_READ = 2'd1,
		OP_LOAD = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC,
		ST_SCROLL,
		ST_DIV,
		ST_READ
	} state_t;

	typedef struct packed {
		logic wr;
		logic rd;
		logic advance;
	} store_ctl_t;

endpackage
`default_nettype wire

FILE: design/tcw_divider.sv
`default_nettype none
module tcw_divider #(
	parameter int DIVISOR = 80
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             start,
	input  wire logic [tcw_pkg::WORD_W-1:0]       dividend,
	output logic                                  done,
	output logic [tcw_pkg::WORD_W-1:0]            quotient,
	output logic [$clog2(DIVISOR)-1:0]            remainder
);
	import tcw_pkg::*;

	localparam int RMW = $clog2(DIVISOR);
	localparam int SH  = WORD_W + RMW;
	localparam int PRW = 2 * WORD_W + 1;
	localparam logic [63:0] RECIP =
		((64'd1 << SH) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);

	logic [WORD_W-1:0] num_q;
	logic [WORD_W-1:0] quo_q;
	logic              go_q;
	logic              done_q;
	logic [PRW-1:0]    prod;
	logic [WORD_W-1:0] rem_full;

	// multiply by the rounded-up reciprocal, keep the high bits
	assign prod     = PRW'(num_q) * PRW'(RECIP);
	assign rem_full = num_q - quo_q * WORD_W'(DIVISOR);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			go_q   <= 1'b0;
			done_q <= 1'b0;
		end else begin
			go_q   <= start;
			done_q <= go_q;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
		end
		if (go_q) begin
			quo_q <= WORD_W'(prod >> SH);
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = RMW'(rem_full);

endmodule
`default_nettype wire

FILE: design/tcw_cell_store.sv
`default_nettype none
module tcw_cell_store #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire tcw_pkg::store_ctl_t            ctl,
	input  wire logic [$clog2(ROWS)-1:0]        row,
	input  wire logic [$clog2(COLUMNS)-1:0]     col,
	input  wire logic [tcw_pkg::CELL_W-1:0]     wr_data,
	output logic [tcw_pkg::CELL_W-1:0]          rd_data
);
	import tcw_pkg::*;

	localparam int RIW   = $clog2(ROWS);
	localparam int CELLS = ROWS * COLUMNS;
	localparam int AW    = $clog2(CELLS);

	logic [CELL_W-1:0] mem [CELLS];
	logic [RIW-1:0]    base_q;
	logic [RIW:0]      sum;
	logic [RIW-1:0]    phys;
	logic [AW-1:0]     addr;

	// rotate logical rows onto physical rows
	assign sum  = {1'b0, row} + {1'b0, base_q};
	assign phys = (sum >= (RIW+1)'(ROWS)) ? RIW'(sum - (RIW+1)'(ROWS)) : RIW'(sum);
	assign addr = AW'(phys) * AW'(COLUMNS) + AW'(col);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
		end else if (ctl.advance) begin
			base_q <= (base_q == RIW'(ROWS - 1)) ? '0 : base_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.wr) begin
			mem[addr] <= wr_data;
		end
		if (ctl.rd) begin
			rd_data <= mem[addr];
		end
	end

endmodule
`default_nettype wire

FILE: design/text_console_writer.sv
`default_nettype none
// Channel    Handshake                  Payload
// command    start & !busy              operation, character, cell_index, cursor_word
// result     done (one cycle)           column, row, cursor_position, cell_char,
//                                       cell_attr, scrolled
// attribute  text_attribute_we          text_attribute
//
// Put character: an execute step, plus a scroll pass when a scroll clears the new bottom row.
// Load cursor and read cell: a reciprocal multiply splits the cursor word or the index
// into row and column, and a read adds a memory read. Other words finish from idle.
// After reset the cell memory is swept to blanks, with busy high.
// Results cannot be stalled; done marks each one for exactly one cycle.
module text_console_writer #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  operation,
	input  wire logic [7:0]  character,
	input  wire logic [10:0] cell_index,
	input  wire logic [15:0] cursor_word,
	output logic             done,
	output logic [6:0]       column,
	output logic [4:0]       row,
	output logic [11:0]      cursor_position,
	output logic [7:0]       cell_char,
	output logic [7:0]       cell_attr,
	output logic             scrolled,
	input  wire logic        text_attribute_we,
	input  wire logic [7:0]  text_attribute
);
	import tcw_pkg::*;

	localparam int CW    = $clog2(COLUMNS + 1);
	localparam int RW    = $clog2(ROWS + 1);
	localparam int CIW   = $clog2(COLUMNS);
	localparam int RIW   = $clog2(ROWS);
	localparam int CELLS = ROWS * COLUMNS;
	localparam int PW    = $clog2(CELLS + COLUMNS + 1);

	state_t             state_q, state_d;
	op_t                op_q;
	logic [7:0]         ch_q;
	logic [7:0]         attr_q;
	logic [CW-1:0]      col_q;
	logic [RW-1:0]      row_q;
	logic [CIW-1:0]     fill_q;
	logic [RIW-1:0]     clr_row_q;
	logic               scr_q;
	logic               done_q;
	logic [CELL_W-1:0]  cell_q;

	logic               accept;
	logic               idle_emit;
	logic               in_range;
	logic               wrap;
	logic [CW-1:0]      c1;
	logic [RW-1:0]      r1;
	logic               need_scroll;
	logic               ch_zero;
	logic               ch_nl;
	logic               fill_last;
	logic               emit;

	store_ctl_t         st_ctl;
	logic [RIW-1:0]     st_row;
	logic [CIW-1:0]     st_col;
	logic [CELL_W-1:0]  st_wdata;
	logic [CELL_W-1:0]  st_rdata;

	logic               div_start;
	logic [WORD_W-1:0]  div_in;
	logic               div_done;
	logic [WORD_W-1:0]  div_quo;
	logic [CIW-1:0]     div_rem;
	logic [PW-1:0]      pos;

	assign accept      = start && (state_q == ST_IDLE);
	assign in_range    = 32'(cell_index) < 32'(CELLS);
	assign wrap        = col_q >= CW'(COLUMNS);
	assign c1          = wrap ? '0 : col_q;
	assign r1          = wrap ? row_q + 1'b1 : row_q;
	assign need_scroll = r1 >= RW'(ROWS);
	assign ch_zero     = ch_q == CHAR_NUL;
	assign ch_nl       = ch_q == CHAR_NEWLINE;
	assign fill_last   = fill_q == CIW'(COLUMNS - 1);

	always_comb begin
		idle_emit = 1'b0;
		case (op_t'(operation))
			OP_PUT:  idle_emit = 1'b0;
			OP_READ: idle_emit = !in_range;
			OP_LOAD: idle_emit = 1'b0;
			default: idle_emit = 1'b1;
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (fill_last && clr_row_q == RIW'(ROWS - 1)) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (accept) begin
					case (op_t'(operation))
						OP_PUT:  state_d = ST_EXEC;
						OP_READ: state_d = in_range ? ST_DIV : ST_IDLE;
						OP_LOAD: state_d = ST_DIV;
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_EXEC: begin
				state_d = (!ch_zero && need_scroll) ? ST_SCROLL : ST_IDLE;
			end
			ST_SCROLL: begin
				if (fill_last) state_d = ST_EXEC;
			end
			ST_DIV: begin
				if (div_done) state_d = (op_q == OP_READ) ? ST_READ : ST_IDLE;
			end
			ST_READ: begin
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		emit      = 1'b0;
		st_ctl    = '0;
		st_row    = RIW'(ROWS - 1);
		st_col    = fill_q;
		st_wdata  = {attr_q, CHAR_SPACE};
		div_start = 1'b0;
		div_in    = cursor_word;
		case (state_q)
			ST_CLEAR: begin
				st_ctl.wr = 1'b1;
				st_row    = clr_row_q;
				st_wdata  = {RESET_ATTR, CHAR_SPACE};
			end
			ST_IDLE: begin
				emit      = accept && idle_emit;
				div_start = accept && ((op_t'(operation) == OP_READ && in_range) ||
					op_t'(operation) == OP_LOAD);
				div_in    = (op_t'(operation) == OP_READ) ? WORD_W'(cell_index) : cursor_word;
			end
			ST_EXEC: begin
				st_row   = RIW'(r1);
				st_col   = CIW'(c1);
				st_wdata = {attr_q, ch_q};
				if (ch_zero) begin
					emit = 1'b1;
				end else if (need_scroll) begin
					st_ctl.advance = 1'b1;
				end else begin
					emit      = 1'b1;
					st_ctl.wr = !ch_nl;
				end
			end
			ST_SCROLL: begin
				st_ctl.wr = 1'b1;
			end
			ST_DIV: begin
				st_row    = RIW'(div_quo);
				st_col    = div_rem;
				st_ctl.rd = div_done && (op_q == OP_READ);
				emit      = div_done && (op_q != OP_READ);
			end
			ST_READ: begin
				emit = 1'b1;
			end
			default: emit = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			op_q      <= OP_PUT;
			ch_q      <= '0;
			attr_q    <= RESET_ATTR;
			col_q     <= '0;
			row_q     <= '0;
			fill_q    <= '0;
			clr_row_q <= '0;
			scr_q     <= 1'b0;
			done_q    <= 1'b0;
			cell_q    <= '0;
		end else begin
			state_q <= state_d;
			done_q  <= emit;
			if (text_attribute_we) begin
				attr_q <= text_attribute;
			end
			case (state_q)
				ST_CLEAR: begin
					fill_q <= fill_last ? '0 : fill_q + 1'b1;
					if (fill_last) clr_row_q <= clr_row_q + 1'b1;
				end
				ST_IDLE: begin
					if (accept) begin
						op_q   <= op_t'(operation);
						ch_q   <= character;
						scr_q  <= 1'b0;
						cell_q <= '0;
					end
				end
				ST_EXEC: begin
					if (!ch_zero) begin
						if (need_scroll) begin
							row_q  <= RW'(ROWS - 1);
							col_q  <= c1;
							scr_q  <= 1'b1;
							fill_q <= '0;
						end else if (ch_nl) begin
							col_q <= '0;
							row_q <= r1 + 1'b1;
						end else begin
							col_q <= c1 + 1'b1;
							row_q <= r1;
						end
					end
				end
				ST_SCROLL: begin
					fill_q <= fill_last ? '0 : fill_q + 1'b1;
				end
				ST_DIV: begin
					if (div_done && op_q == OP_LOAD) begin
						col_q <= CW'(div_rem);
						row_q <= (div_quo >= WORD_W'(ROWS)) ? '0 : RW'(div_quo);
					end
				end
				ST_READ: begin
					cell_q <= st_rdata;
				end
				default: cell_q <= cell_q;
			endcase
		end
	end

	tcw_cell_store #(
		.COLUMNS(COLUMNS),
		.ROWS   (ROWS)
	) u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (st_ctl),
		.row    (st_row),
		.col    (st_col),
		.wr_data(st_wdata),
		.rd_data(st_rdata)
	);

	tcw_divider #(
		.DIVISOR(COLUMNS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_in),
		.done     (div_done),
		.quotient (div_quo),
		.remainder(div_rem)
	);

	assign pos = PW'(row_q) * PW'(COLUMNS) + PW'(col_q);

	assign busy            = state_q != ST_IDLE;
	assign done            = done_q;
	assign column          = 7'(col_q);
	assign row             = 5'(row_q);
	assign cursor_position = 12'(pos);
	assign cell_char       = cell_q[7:0];
	assign cell_attr       = cell_q[15:8];
	assign scrolled        = scr_q;

endmodule
`default_nettype wire

FILE: dv/tb.sv
`default_nettype none
module tb;
	import tcw_pkg::*;

	localparam int COLS        = 80;
	localparam int ROWS_N      = 25;
	localparam int CELLS       = COLS * ROWS_N;
	localparam int RAND_WORDS  = 250;
	localparam int PHASES      = 5;
	localparam int CYCLE_LIMIT = 1_000_000;
	localparam logic [1:0] OP_SPARE = 2'd3;

	typedef struct packed {
		logic [1:0]  operation;
		logic [7:0]  character;
		logic [10:0] cell_index;
		logic [15:0] cursor_word;
	} cmd_word_t;

	typedef struct packed {
		logic [6:0]  column;
		logic [4:0]  row;
		logic [11:0] cursor_position;
		logic [7:0]  cell_char;
		logic [7:0]  cell_attr;
		logic        scrolled;
	} console_view_t;

	typedef struct packed {
		cmd_word_t     cmd;
		logic          typed;
		console_view_t view;
	} script_row_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  operation;
	logic [7:0]  character;
	logic [10:0] cell_index;
	logic [15:0] cursor_word;
	logic        done;
	logic [6:0]  column;
	logic [4:0]  row;
	logic [11:0] cursor_position;
	logic [7:0]  cell_char;
	logic [7:0]  cell_attr;
	logic        scrolled;
	logic        text_attribute_we;
	logic [7:0]  text_attribute;

	logic [15:0]   screen [CELLS];
	int unsigned   cur_col;
	int unsigned   cur_row;
	logic [7:0]    attr_reg;
	console_view_t expected_views [$];
	int unsigned   mismatches;
	int unsigned   cycle_count;
	int unsigned   burst_left;

	text_console_writer dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.start             (start),
		.busy              (busy),
		.operation         (operation),
		.character         (character),
		.cell_index        (cell_index),
		.cursor_word       (cursor_word),
		.done              (done),
		.column            (column),
		.row               (row),
		.cursor_position   (cursor_position),
		.cell_char         (cell_char),
		.cell_attr         (cell_attr),
		.scrolled          (scrolled),
		.text_attribute_we (text_attribute_we),
		.text_attribute    (text_attribute)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic console_view_t console_step(cmd_word_t w);
		console_view_t v;
		int unsigned   i;
		v = '0;
		case (w.operation)
			OP_PUT: begin
				if (w.character != CHAR_NUL) begin
					if (cur_col >= COLS) begin
						cur_col = 0;
						cur_row++;
					end
					if (cur_row >= ROWS_N) begin
						for (i = 0; i < CELLS - COLS; i++)
							screen[i] = screen[i + COLS];
						for (i = CELLS - COLS; i < CELLS; i++)
							screen[i] = {attr_reg, CHAR_SPACE};
						v.scrolled = 1'b1;
						cur_row = ROWS_N - 1;
					end
					if (w.character == CHAR_NEWLINE) begin
						cur_col = 0;
						cur_row++;
					end else begin
						screen[cur_row * COLS + cur_col] = {attr_reg, w.character};
						cur_col++;
					end
				end
			end
			OP_READ: begin
				if (w.cell_index < CELLS)
					{v.cell_attr, v.cell_char} = screen[w.cell_index];
			end
			OP_LOAD: begin
				cur_col = w.cursor_word % COLS;
				cur_row = w.cursor_word / COLS;
				if (cur_row >= ROWS_N)
					cur_row = 0;
			end
			default: ;
		endcase
		v.column          = cur_col[6:0];
		v.row             = cur_row[4:0];
		v.cursor_position = 12'(cur_row * COLS + cur_col);
		return v;
	endfunction

	function automatic cmd_word_t random_word();
		cmd_word_t   w;
		int unsigned pick;
		int unsigned sub;
		w.operation   = OP_PUT;
		w.character   = 8'($urandom);
		w.cell_index  = 11'($urandom);
		w.cursor_word = 16'($urandom);
		pick = $urandom_range(0, 99);
		sub  = $urandom_range(0, 99);
		if (pick < 70) begin
			if (sub < 3)
				w.character = CHAR_NUL;
			else if (sub < 18)
				w.character = CHAR_NEWLINE;
			else
				w.character = 8'($urandom_range(1, 255));
		end else if (pick < 85) begin
			w.operation  = OP_READ;
			w.cell_index = (sub < 10) ? 11'($urandom_range(CELLS, 2047))
				: 11'($urandom_range(0, CELLS - 1));
		end else if (pick < 95) begin
			w.operation = OP_LOAD;
			if (sub < 50)
				w.cursor_word = 16'($urandom_range(CELLS - 2 * COLS, CELLS - 1));
			else if (sub < 80)
				w.cursor_word = 16'($urandom_range(0, CELLS + COLS));
		end else begin
			w.operation = OP_SPARE;
		end
		return w;
	endfunction

	task automatic flag_mismatch(string msg);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch: %s", msg);
	endtask

	// hold start high across back-to-back words; drop it only for a gap
	task automatic send(cmd_word_t w, logic typed, console_view_t typed_view);
		console_view_t v;
		operation   <= w.operation;
		character   <= w.character;
		cell_index  <= w.cell_index;
		cursor_word <= w.cursor_word;
		start       <= 1'b1;
		do @(posedge clk); while (busy);
		v = console_step(w);
		expected_views.push_back(typed ? typed_view : v);
		if (burst_left == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 150)
				: $urandom_range(1, 20);
		end else begin
			burst_left--;
		end
	endtask

	task automatic settle();
		start <= 1'b0;
		while (expected_views.size() != 0 || busy)
			@(posedge clk);
	endtask

	task automatic write_attr(logic [7:0] a);
		text_attribute    <= a;
		text_attribute_we <= 1'b1;
		@(posedge clk);
		attr_reg = a;
		text_attribute_we <= 1'b0;
	endtask

	always @(posedge clk) begin : check_results
		console_view_t got;
		console_view_t want;
		if (done) begin
			got = {column, row, cursor_position, cell_char, cell_attr, scrolled};
			if (expected_views.size() == 0) begin
				flag_mismatch($sformatf("unexpected word col %0d row %0d pos %0d",
					column, row, cursor_position));
			end else begin
				want = expected_views.pop_front();
				if (got !== want)
					flag_mismatch($sformatf(
						"exp col %0d row %0d pos %0d ch %h at %h sc %b, got col %0d row %0d pos %0d ch %h at %h sc %b",
						want.column, want.row, want.cursor_position, want.cell_char,
						want.cell_attr, want.scrolled, got.column, got.row,
						got.cursor_position, got.cell_char, got.cell_attr, got.scrolled));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("text_console_writer test failed");
			$finish;
		end
	end

	initial begin : stimulus
		script_row_t script [25];
		int unsigned i;
		int unsigned ph;
		int unsigned n;
		clk               = 1'b0;
		arst_n            = 1'b0;
		start             = 1'b0;
		operation         = OP_PUT;
		character         = CHAR_NUL;
		cell_index        = '0;
		cursor_word       = '0;
		text_attribute_we = 1'b0;
		text_attribute    = RESET_ATTR;
		mismatches        = 0;
		cycle_count       = 0;
		burst_left        = 5;
		cur_col           = 0;
		cur_row           = 0;
		attr_reg          = RESET_ATTR;
		for (i = 0; i < CELLS; i++)
			screen[i] = {RESET_ATTR, CHAR_SPACE};
		script = '{
			'{'{OP_READ, 8'h00, 11'd0, 16'd0}, 1'b1, '{7'd0, 5'd0, 12'd0, CHAR_SPACE, RESET_ATTR, 1'b0}},
			'{'{OP_READ, 8'h00, 11'd1999, 16'd0}, 1'b1, '{7'd0, 5'd0, 12'd0, CHAR_SPACE, RESET_ATTR, 1'b0}},
			'{'{OP_READ, 8'h00, 11'd2047, 16'd0}, 1'b1, '{7'd0, 5'd0, 12'd0, 8'h00, 8'h00, 1'b0}},
			'{'{OP_SPARE, 8'hFF, 11'h7FF, 16'hFFFF}, 1'b1, '{7'd0, 5'd0, 12'd0, 8'h00, 8'h00, 1'b0}},
			'{'{OP_PUT, CHAR_NUL, 11'd0, 16'd0}, 1'b1, '{7'd0, 5'd0, 12'd0, 8'h00, 8'h00, 1'b0}},
			'{'{OP_PUT, 8'h41, 11'd0, 16'd0}, 1'b1, '{7'd1, 5'd0, 12'd1, 8'h00, 8'h00, 1'b0}},
			'{'{OP_PUT, 8'hFF, 11'd0, 16'd0}, 1'b1, '{7'd2, 5'd0, 12'd2, 8'h00, 8'h00, 1'b0}},
			'{'{OP_READ, 8'h00, 11'd1, 16'd0}, 1'b1, '{7'd2, 5'd0, 12'd2, 8'hFF, RESET_ATTR, 1'b0}},
			'{'{OP_PUT, CHAR_NEWLINE, 11'd0, 16'd0}, 1'b1, '{7'd0, 5'd1, 12'd80, 8'h00, 8'h00, 1'b0}},
			'{'{OP_LOAD, 8'h00, 11'd0, 16'd79}, 1'b1, '{7'd79, 5'd0, 12'd79, 8'h00, 8'h00, 1'b0}},
			'{'{OP_PUT, 8'h78, 11'd0, 16'd0}, 1'b1, '{7'd80, 5'd0, 12'd80, 8'h00, 8'h00, 1'b0}},
			'{'{OP_PUT, 8'h79, 11'd0, 16'd0}, 1'b1, '{7'd1, 5'd1, 12'd81, 8'h00, 8'h00, 1'b0}},
			'{'{OP_READ, 8'h00, 11'd80, 16'd0}, 1'b1, '{7'd1, 5'd1, 12'd81, 8'h79, RESET_ATTR, 1'b0}},
			'{'{OP_LOAD, 8'h00, 11'd0, 16'd1999}, 1'b1, '{7'd79, 5'd24, 12'd1999, 8'h00, 8'h00, 1'b0}},
			'{'{OP_PUT, 8'h7A, 11'd0, 16'd0}, 1'b1, '{7'd80, 5'd24, 12'd2000, 8'h00, 8'h00, 1'b0}},
			'{'{OP_PUT, CHAR_NEWLINE, 11'd0, 16'd0}, 1'b1, '{7'd0, 5'd25, 12'd2000, 8'h00, 8'h00, 1'b1}},
			'{'{OP_PUT, 8'h71, 11'd0, 16'd0}, 1'b1, '{7'd1, 5'd24, 12'd1921, 8'h00, 8'h00, 1'b1}},
			'{'{OP_READ, 8'h00, 11'd1839, 16'd0}, 1'b1, '{7'd1, 5'd24, 12'd1921, 8'h7A, RESET_ATTR, 1'b0}},
			'{'{OP_READ, 8'h00, 11'd1921, 16'd0}, 1'b1, '{7'd1, 5'd24, 12'd1921, CHAR_SPACE, RESET_ATTR, 1'b0}},
			'{'{OP_LOAD, 8'h00, 11'd0, 16'd2000}, 1'b1, '{7'd0, 5'd0, 12'd0, 8'h00, 8'h00, 1'b0}},
			'{'{OP_LOAD, 8'h00, 11'd0, 16'hFFFF}, 1'b1, '{7'd15, 5'd0, 12'd15, 8'h00, 8'h00, 1'b0}},
			'{'{OP_LOAD, 8'h00, 11'd0, 16'h5555}, 1'b0, '0},
			'{'{OP_PUT, 8'h80, 11'd0, 16'd0}, 1'b0, '0},
			'{'{OP_READ, 8'h00, 11'h2AA, 16'd0}, 1'b0, '0},
			'{'{OP_READ, 8'h00, 11'h555, 16'd0}, 1'b0, '0}
		};
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		foreach (script[k])
			send(script[k].cmd, script[k].typed, script[k].view);
		for (ph = 0; ph < PHASES; ph++) begin
			settle();
			write_attr((ph == 0) ? 8'h00 : (ph == 1) ? 8'hFF : 8'($urandom));
			for (n = 0; n < RAND_WORDS; n++)
				send(random_word(), 1'b0, '0);
		end
		settle();
		repeat (100) @(posedge clk);
		if (mismatches == 0)
			$display("text_console_writer test passed");
		else
			$display("text_console_writer test failed");
		$finish;
	end
endmodule
`default_nettype wire
